@@ rtl/dpr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dpr_pkg
// Constants, lane types and divider step functions for the depth pixel
// reprojection pipeline.
// ----------------------------------------------------------------------------
package dpr_pkg;

   // source coordinate width (coordinates wrap modulo 2^CoordBits)
   localparam int CoordBits = 12;
   localparam logic [11:0] CoordMask = 12'((64'd1 << CoordBits) - 64'd1);

   // register indexes
   localparam logic [2:0] RegFocalX  = 3'd0;
   localparam logic [2:0] RegFocalY  = 3'd1;
   localparam logic [2:0] RegCenterX = 3'd2;
   localparam logic [2:0] RegCenterY = 3'd3;
   localparam logic [2:0] RegWidth   = 3'd4;
   localparam logic [2:0] RegHeight  = 3'd5;

   // register reset values
   localparam logic [23:0] FocalXReset  = 24'd3763127;
   localparam logic [23:0] FocalYReset  = 24'd3764607;
   localparam logic [23:0] CenterXReset = 24'd2654687;
   localparam logic [23:0] CenterYReset = 24'd1516049;
   localparam logic [11:0] WidthReset   = 12'd3072;
   localparam logic [11:0] HeightReset  = 12'd2048;

   // rigid transform, Q.20
   localparam logic signed [21:0] RotQ20 [0:2][0:2] = '{
      '{ 22'sd1047852,  22'sd36774,    22'sd12842   },
      '{ -22'sd37918,   22'sd1042126,  22'sd109760  },
      '{ -22'sd8913,    -22'sd110149,  22'sd1042737 }
   };
   localparam logic signed [23:0] TrnQ20 [0:2] = '{
      -24'sd247893, -24'sd2788072, 24'sd366914
   };

   // divider depths: back-projection quotient and projection quotient
   localparam int Div1Steps = 37;
   localparam int Div2Steps = 26;

   // back-projection divider lane: remainder, numerator/quotient shift word
   typedef struct packed {
      logic [23:0] rem;
      logic [36:0] nq;
      logic        neg;
      logic        ovf;
   } div1_lane_type;

   // projection divider lane
   typedef struct packed {
      logic [38:0] rem;
      logic [25:0] nq;
      logic        neg;
      logic        ovf;
   } div2_lane_type;

   // one restoring step, 24-bit divisor
   function automatic div1_lane_type div1_step(div1_lane_type a, logic [23:0] d);
      logic [24:0]   sh;
      div1_lane_type r;
      sh = {a.rem, a.nq[36]};
      r  = a;
      if (sh >= {1'b0, d}) begin
         r.rem = 24'(sh - {1'b0, d});
         r.nq  = {a.nq[35:0], 1'b1};
      end else begin
         r.rem = sh[23:0];
         r.nq  = {a.nq[35:0], 1'b0};
      end
      return r;
   endfunction

   // one restoring step, 39-bit divisor
   function automatic div2_lane_type div2_step(div2_lane_type a, logic [38:0] d);
      logic [39:0]   sh;
      div2_lane_type r;
      sh = {a.rem, a.nq[25]};
      r  = a;
      if (sh >= {1'b0, d}) begin
         r.rem = 39'(sh - {1'b0, d});
         r.nq  = {a.nq[24:0], 1'b1};
      end else begin
         r.rem = sh[38:0];
         r.nq  = {a.nq[24:0], 1'b0};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ rtl/depth_pixel_reprojection.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// depth_pixel_reprojection
// Back-projects a depth pixel, applies a fixed rigid transform and projects
// it into the target camera; emits the point when it lands inside the frame.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  req     | req_valid/ready, pixel_col/row, depth   | in
//  rsp     | rsp_valid/ready, proj_col/row, depth    | out
//  csr     | csr_wr_en, csr_index, csr_wdata         | in, write only
//
//  One request per cycle while the output is not stalled, through the
//  37-step and 26-step pipelined restoring dividers plus multiply/add stages.
//  Synchronous reset clears the stage valid bits and presets the registers.
//  A stalled output freezes the whole pipeline; dropped pixels leave bubbles.
// ----------------------------------------------------------------------------
module depth_pixel_reprojection
   import dpr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [11:0] req_pixel_col,
   input  wire logic [11:0] req_pixel_row,
   input  wire logic [23:0] req_depth_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [19:0]      rsp_proj_col,
   output logic [19:0]      rsp_proj_row,
   output logic [23:0]      rsp_depth_out,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   // stage types
   typedef struct packed {
      logic               v;
      logic signed [24:0] du;
      logic signed [24:0] dv;
      logic [23:0]        depth;
   } s1_type;

   typedef struct packed {
      logic               v;
      logic signed [49:0] nx;
      logic signed [49:0] ny;
      logic [23:0]        depth;
   } s2_type;

   typedef struct packed {
      logic          v;
      div1_lane_type lx;
      div1_lane_type ly;
      logic [23:0]   depth;
   } d1_type;

   typedef struct packed {
      logic               v;
      logic signed [38:0] p0;
      logic signed [38:0] p1;
      logic signed [38:0] p2;
      logic [23:0]        depth;
   } s4_type;

   typedef struct packed {
      logic                      v;
      logic signed [2:0][2:0][60:0] prod;
      logic [23:0]               depth;
   } s5_type;

   typedef struct packed {
      logic               v;
      logic signed [39:0] q0;
      logic signed [39:0] q1;
      logic [38:0]        q2;
      logic [23:0]        depth;
   } s6_type;

   typedef struct packed {
      logic               v;
      logic [43:0]        xlo;
      logic signed [44:0] xhi;
      logic [43:0]        ylo;
      logic signed [44:0] yhi;
      logic [38:0]        q2;
      logic [23:0]        depth;
   } s7_type;

   typedef struct packed {
      logic               v;
      logic signed [63:0] nx;
      logic signed [63:0] ny;
      logic [38:0]        q2;
      logic [23:0]        depth;
   } s8_type;

   typedef struct packed {
      logic          v;
      div2_lane_type lx;
      div2_lane_type ly;
      logic [38:0]   q2;
      logic [23:0]   depth;
   } d2_type;

   logic [23:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic [11:0] width_ff, height_ff;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   d1_type d1_ff [0:Div1Steps];
   d1_type d1_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   s7_type s7_ff, s7_in;
   s8_type s8_ff, s8_in;
   d2_type d2_ff [0:Div2Steps];
   d2_type d2_in;

   logic        out_v_ff, out_v_in;
   logic [19:0] out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [23:0] out_depth_ff;

   logic adv;

   // whole pipeline moves unless a result waits at a stalled output
   assign adv       = !out_v_ff || rsp_ready;
   assign req_ready = adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= FocalXReset;
         focal_y_ff  <= FocalYReset;
         center_x_ff <= CenterXReset;
         center_y_ff <= CenterYReset;
         width_ff    <= WidthReset;
         height_ff   <= HeightReset;
      end else if (csr_wr_en) begin
         case (csr_index)
            RegFocalX:  focal_x_ff  <= csr_wdata;
            RegFocalY:  focal_y_ff  <= csr_wdata;
            RegCenterX: center_x_ff <= csr_wdata;
            RegCenterY: center_y_ff <= csr_wdata;
            RegWidth:   width_ff    <= csr_wdata[11:0];
            RegHeight:  height_ff   <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // stage 1: offsets from the principal point, early drop
   always_comb begin
      logic [11:0] col, row;
      col         = req_pixel_col & CoordMask;
      row         = req_pixel_row & CoordMask;
      s1_in.v     = req_valid && (req_depth_in != 24'd0) &&
                    (focal_x_ff != 24'd0) && (focal_y_ff != 24'd0);
      s1_in.du    = $signed({1'b0, col, 12'd0}) - $signed({1'b0, center_x_ff});
      s1_in.dv    = $signed({1'b0, row, 12'd0}) - $signed({1'b0, center_y_ff});
      s1_in.depth = req_depth_in;
   end

   // stage 2: depth times offset
   always_comb begin
      s2_in.v     = s1_ff.v;
      s2_in.nx    = $signed({1'b0, s1_ff.depth}) * s1_ff.du;
      s2_in.ny    = $signed({1'b0, s1_ff.depth}) * s1_ff.dv;
      s2_in.depth = s1_ff.depth;
   end

   // stage 3: magnitudes and divider setup; ovf marks a quotient past 2^37
   function automatic div1_lane_type div1_init(logic signed [49:0] n, logic [23:0] d);
      logic [49:0]   a;
      logic [52:0]   mag;
      div1_lane_type r;
      a     = n[49] ? 50'(-n) : n;
      mag   = {a[48:0], 4'd0};
      r.neg = n[49];
      r.rem = {8'd0, mag[52:37]};
      r.nq  = mag[36:0];
      r.ovf = ({8'd0, mag[52:37]} >= d);
      return r;
   endfunction

   always_comb begin
      d1_in.v     = s2_ff.v;
      d1_in.lx    = div1_init(s2_ff.nx, focal_x_ff);
      d1_in.ly    = div1_init(s2_ff.ny, focal_y_ff);
      d1_in.depth = s2_ff.depth;
   end

   // stage 4: saturate the lateral coordinates to +-2^36
   function automatic logic signed [38:0] clamp_lat(div1_lane_type l);
      logic [37:0] q;
      q = {1'b0, l.nq};
      if (l.ovf || q > (38'd1 << 36)) q = 38'd1 << 36;
      return l.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
   endfunction

   always_comb begin
      s4_in.v     = d1_ff[Div1Steps].v;
      s4_in.p0    = clamp_lat(d1_ff[Div1Steps].lx);
      s4_in.p1    = clamp_lat(d1_ff[Div1Steps].ly);
      s4_in.p2    = $signed({11'd0, d1_ff[Div1Steps].depth, 4'd0});
      s4_in.depth = d1_ff[Div1Steps].depth;
   end

   // stage 5: rotation products
   always_comb begin
      logic signed [38:0] p [0:2];
      p[0] = s4_ff.p0;
      p[1] = s4_ff.p1;
      p[2] = s4_ff.p2;
      s5_in.v     = s4_ff.v;
      s5_in.depth = s4_ff.depth;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s5_in.prod[i][j] = RotQ20[i][j] * p[j];
         end
      end
   end

   // stage 6: row sums plus translation, truncate toward zero to Q.20
   always_comb begin
      logic signed [63:0] acc [0:2];
      logic signed [39:0] q   [0:2];
      for (int i = 0; i < 3; i++) begin
         acc[i] = 64'($signed(s5_ff.prod[i][0])) + 64'($signed(s5_ff.prod[i][1])) +
                  64'($signed(s5_ff.prod[i][2])) + (64'(TrnQ20[i]) <<< 20);
         if (acc[i] < 0) acc[i] = acc[i] + 64'sd1048575;
         q[i] = 40'(acc[i] >>> 20);
      end
      s6_in.q0    = q[0];
      s6_in.q1    = q[1];
      s6_in.q2    = q[2][38:0];
      s6_in.v     = s5_ff.v && (q[2] > 40'sd0);
      s6_in.depth = s5_ff.depth;
   end

   // stage 7: focal times coordinate as two partial products
   always_comb begin
      s7_in.v     = s6_ff.v;
      s7_in.xlo   = focal_x_ff * s6_ff.q0[19:0];
      s7_in.xhi   = $signed({1'b0, focal_x_ff}) * $signed(s6_ff.q0[39:20]);
      s7_in.ylo   = focal_y_ff * s6_ff.q1[19:0];
      s7_in.yhi   = $signed({1'b0, focal_y_ff}) * $signed(s6_ff.q1[39:20]);
      s7_in.q2    = s6_ff.q2;
      s7_in.depth = s6_ff.depth;
   end

   // stage 8: combine partial products
   always_comb begin
      s8_in.v     = s7_ff.v;
      s8_in.nx    = 64'($signed({s7_ff.xhi, 20'd0}) + $signed({1'b0, s7_ff.xlo}));
      s8_in.ny    = 64'($signed({s7_ff.yhi, 20'd0}) + $signed({1'b0, s7_ff.ylo}));
      s8_in.q2    = s7_ff.q2;
      s8_in.depth = s7_ff.depth;
   end

   // stage 9: projection divider setup; ovf means the point is off frame
   function automatic div2_lane_type div2_init(logic signed [63:0] n, logic [38:0] d);
      logic [63:0]   a;
      div2_lane_type r;
      a     = n[63] ? 64'(-n) : n;
      r.neg = n[63];
      r.rem = {2'd0, a[62:26]};
      r.nq  = a[25:0];
      r.ovf = ({2'd0, a[62:26]} >= d);
      return r;
   endfunction

   always_comb begin
      d2_in.v     = s8_ff.v;
      d2_in.lx    = div2_init(s8_ff.nx, s8_ff.q2);
      d2_in.ly    = div2_init(s8_ff.ny, s8_ff.q2);
      d2_in.q2    = s8_ff.q2;
      d2_in.depth = s8_ff.depth;
   end

   // output: add principal point, frame test
   function automatic logic signed [27:0] add_center(div2_lane_type l, logic [23:0] c);
      logic signed [26:0] sq;
      sq = l.neg ? -$signed({1'b0, l.nq}) : $signed({1'b0, l.nq});
      return $signed({sq[26], sq}) + $signed({4'd0, c});
   endfunction

   always_comb begin
      logic signed [27:0] c12, r12;
      logic               in_frame;
      c12      = add_center(d2_ff[Div2Steps].lx, center_x_ff);
      r12      = add_center(d2_ff[Div2Steps].ly, center_y_ff);
      in_frame = (c12 > 28'sd0) && (r12 > 28'sd0) &&
                 (c12 < $signed({4'd0, width_ff, 12'd0})) &&
                 (r12 < $signed({4'd0, height_ff, 12'd0}));
      out_v_in   = d2_ff[Div2Steps].v && !d2_ff[Div2Steps].lx.ovf &&
                   !d2_ff[Div2Steps].ly.ovf && in_frame;
      out_col_in = c12[23:4];
      out_row_in = r12[23:4];
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.v  <= 1'b0;
         s2_ff.v  <= 1'b0;
         s4_ff.v  <= 1'b0;
         s5_ff.v  <= 1'b0;
         s6_ff.v  <= 1'b0;
         s7_ff.v  <= 1'b0;
         s8_ff.v  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s4_ff        <= s4_in;
         s5_ff        <= s5_in;
         s6_ff        <= s6_in;
         s7_ff        <= s7_in;
         s8_ff        <= s8_in;
         out_v_ff     <= out_v_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_depth_ff <= d2_ff[Div2Steps].depth;
      end
   end

   // back-projection divider, one quotient bit per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= Div1Steps; k++) d1_ff[k].v <= 1'b0;
      end else if (adv) begin
         d1_ff[0] <= d1_in;
         for (int k = 0; k < Div1Steps; k++) begin
            d1_ff[k+1].v     <= d1_ff[k].v;
            d1_ff[k+1].lx    <= div1_step(d1_ff[k].lx, focal_x_ff);
            d1_ff[k+1].ly    <= div1_step(d1_ff[k].ly, focal_y_ff);
            d1_ff[k+1].depth <= d1_ff[k].depth;
         end
      end
   end

   // projection divider, divisor is the transformed depth
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= Div2Steps; k++) d2_ff[k].v <= 1'b0;
      end else if (adv) begin
         d2_ff[0] <= d2_in;
         for (int k = 0; k < Div2Steps; k++) begin
            d2_ff[k+1].v     <= d2_ff[k].v;
            d2_ff[k+1].lx    <= div2_step(d2_ff[k].lx, d2_ff[k].q2);
            d2_ff[k+1].ly    <= div2_step(d2_ff[k].ly, d2_ff[k].q2);
            d2_ff[k+1].q2    <= d2_ff[k].q2;
            d2_ff[k+1].depth <= d2_ff[k].depth;
         end
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_proj_col  = out_col_ff;
   assign rsp_proj_row  = out_row_ff;
   assign rsp_depth_out = out_depth_ff;

endmodule
`default_nettype wire
